>>> hw/rtl/pcsa_pkg.sv
// Shared types, sizes and tables for the PCSA distinct counter.
// No dependencies; imported by every module of the block.
`default_nettype none

package pcsa_pkg;

  localparam int unsigned NumRegs  = 64;
  localparam int unsigned IdxW     = $clog2(NumRegs);
  localparam int unsigned HashBits = 32;
  localparam int unsigned RestW    = HashBits - IdxW;
  localparam int unsigned RegBits  = 32;
  localparam int unsigned PosW     = $clog2(RegBits);
  localparam int unsigned CntW     = $clog2(RegBits + 1);
  localparam int unsigned SumW     = 12;
  localparam int unsigned EstW     = 39;
  localparam int unsigned PhiW     = 17;
  localparam int unsigned PW       = 18;
  localparam int unsigned ProdW    = PhiW + PW;
  localparam int unsigned ScaleW   = ProdW + IdxW;
  localparam int unsigned QW       = SumW - IdxW;

  localparam logic [PhiW-1:0] PhiReset = PhiW'(84727);
  localparam logic [EstW-1:0] EstMax   = {EstW{1'b1}};

  localparam logic CmdAdd   = 1'b0;
  localparam logic CmdMerge = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [HashBits-1:0] hash_value;
    logic [5:0]          bitmap_index;
    logic [31:0]         merge_word;
  } in_item_t;

  typedef struct packed {
    logic [EstW-1:0] estimate;
    logic [SumW-1:0] ones_sum;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [IdxW-1:0]    idx;
    logic [RegBits-1:0] bits;
  } upd_req_t;

  // number of consecutive ones from bit 0 up
  function automatic logic [CntW-1:0] low_ones(input logic [RegBits-1:0] w);
    logic [RegBits:0] ext;
    logic [RegBits:0] t;
    logic [CntW-1:0]  n;
    ext = {1'b0, w};
    t   = ~ext & (ext + {{RegBits{1'b0}}, 1'b1});
    n   = '0;
    for (int i = 0; i <= RegBits; i++) begin
      if (t[i]) n = n | CntW'(i);
    end
    return n;
  endfunction

  // 2^(k/16) in Q16
  function automatic logic [PW-1:0] pow2_frac(input logic [4:0] k);
    logic [PW-1:0] v;
    unique case (k)
      5'd0:    v = PW'(65536);
      5'd1:    v = PW'(68438);
      5'd2:    v = PW'(71468);
      5'd3:    v = PW'(74632);
      5'd4:    v = PW'(77936);
      5'd5:    v = PW'(81386);
      5'd6:    v = PW'(84990);
      5'd7:    v = PW'(88752);
      5'd8:    v = PW'(92682);
      5'd9:    v = PW'(96785);
      5'd10:   v = PW'(101070);
      5'd11:   v = PW'(105545);
      5'd12:   v = PW'(110218);
      5'd13:   v = PW'(115098);
      5'd14:   v = PW'(120193);
      5'd15:   v = PW'(125515);
      default: v = PW'(131072);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pcsa_update.sv
// Bitmap store with read-modify-write and the running leading-ones sum.
// Depends on pcsa_pkg.
`default_nettype none

module pcsa_update (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pcsa_pkg::upd_req_t        req_i,
  output logic                           done_o,
  output logic [pcsa_pkg::SumW-1:0]      ones_total_o
);
  import pcsa_pkg::*;

  logic [RegBits-1:0] mem [NumRegs];
  logic [RegBits-1:0] rd_data_q;
  logic [NumRegs-1:0] vld_q;
  logic               s1_valid_q;
  logic [IdxW-1:0]    s1_idx_q;
  logic [RegBits-1:0] s1_bits_q;
  logic               done_q;
  logic [SumW-1:0]    total_q, total_d;
  logic [RegBits-1:0] old_w, new_w;

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      rd_data_q <= mem[req_i.idx];
    end
    if (s1_valid_q) begin
      mem[s1_idx_q] <= new_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      s1_idx_q  <= req_i.idx;
      s1_bits_q <= req_i.bits;
    end
  end

  assign old_w   = vld_q[s1_idx_q] ? rd_data_q : '0;
  assign new_w   = old_w | s1_bits_q;
  assign total_d = total_q - SumW'(low_ones(old_w)) + SumW'(low_ones(new_w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
      vld_q      <= '0;
      total_q    <= '0;
    end else begin
      s1_valid_q <= req_i.valid;
      done_q     <= s1_valid_q;
      if (s1_valid_q) begin
        vld_q[s1_idx_q] <= 1'b1;
        total_q         <= total_d;
      end
    end
  end

  assign done_o       = done_q;
  assign ones_total_o = total_q;

endmodule

`default_nettype wire

>>> hw/rtl/pcsa_estimate.sv
// Estimate pipeline: table interpolation, scale by 1/phi, shift and saturate.
// Depends on pcsa_pkg.
`default_nettype none

module pcsa_estimate (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [pcsa_pkg::SumW-1:0] ones_total_i,
  input  wire logic [pcsa_pkg::PhiW-1:0] phi_i,
  input  wire logic                      res_ready_i,
  output logic                           res_valid_o,
  output logic [pcsa_pkg::EstW-1:0]      estimate_o
);
  import pcsa_pkg::*;

  logic                a_vld_q, b_vld_q;
  logic [PW-1:0]       p_q, p_d;
  logic [QW-1:0]       qa_q, qb_q;
  logic [ProdW-1:0]    prod_q;
  logic [PW-1:0]       lo, hi, diff;
  logic [PW+1:0]       dj;
  logic [4:0]          k;
  logic [ScaleW+31:0]  wide;
  logic [ScaleW-1:0]   v;

  assign k    = {1'b0, ones_total_i[IdxW-1:2]};
  assign lo   = pow2_frac(k);
  assign hi   = pow2_frac(k + 5'd1);
  assign diff = hi - lo;
  assign dj   = (PW+2)'(diff) * (PW+2)'(ones_total_i[1:0]);
  assign p_d  = lo + PW'(dj >> 2);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q  <= p_d;
      qa_q <= ones_total_i[SumW-1:IdxW];
    end
    if (a_vld_q) begin
      prod_q <= ProdW'(phi_i) * ProdW'(p_q);
      qb_q   <= qa_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i;
      if (a_vld_q) begin
        b_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        b_vld_q <= 1'b0;
      end
    end
  end

  // estimate = (prod * 2^6) * 2^q / 2^32
  assign wide = {32'b0, prod_q, {IdxW{1'b0}}} << qb_q;
  assign v    = wide[ScaleW+31:32];

  always_comb begin
    if (qb_q > QW'(32)) begin
      estimate_o = (prod_q != '0) ? EstMax : '0;
    end else if (v[ScaleW-1:EstW] != '0) begin
      estimate_o = EstMax;
    end else begin
      estimate_o = v[EstW-1:0];
    end
  end

  assign res_valid_o = b_vld_q;

endmodule

`default_nettype wire

>>> hw/rtl/pcsa_distinct_counter.sv
// PCSA distinct counter: top level with handshake, decode and result register.
// Depends on pcsa_pkg, pcsa_update and pcsa_estimate.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one item: an add of a hashed
//   element (cmd 0) or an OR of a word into one bitmap (cmd 1).
//   Output channel out_valid_o/out_ready_i returns one result per item: the
//   distinct count estimate and the running leading-ones sum.
//   An item passes the bitmap read, write-back, table step and multiply
//   registers, then the output register. The block holds one item at a time,
//   so the next item is taken once the result loads the output register.
//   A result waiting in the output register does not block the next item;
//   the next result waits in the estimate pipeline until the output frees.
//   Reset clears all bitmaps (through per-entry valid bits), the running sum
//   and loads 1/phi with its default. cfg_we_i writes 1/phi (Q16); write it
//   only while the block is idle.
`default_nettype none

module pcsa_distinct_counter (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire pcsa_pkg::in_item_t        in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output pcsa_pkg::out_item_t            out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [pcsa_pkg::PhiW-1:0] cfg_wdata_i
);
  import pcsa_pkg::*;

  logic               busy_q;
  logic               in_xfer;
  logic [PhiW-1:0]    phi_q;
  logic [RestW-1:0]   rest;
  logic [PosW-1:0]    pos;
  upd_req_t           req;
  logic               done;
  logic [SumW-1:0]    total;
  logic               res_valid;
  logic [EstW-1:0]    estimate;
  logic               load;
  logic               out_valid_q;
  out_item_t          out_q;

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign rest = in_data_i.hash_value[HashBits-1:IdxW];

  always_comb begin
    if (rest == '0) begin
      pos = PosW'(RegBits - 1);
    end else begin
      pos = PosW'(low_ones({{(RegBits-RestW){1'b0}}, ~rest}));
    end
  end

  always_comb begin
    req.valid = in_xfer;
    unique case (in_data_i.cmd)
      CmdAdd: begin
        req.idx  = in_data_i.hash_value[IdxW-1:0];
        req.bits = {{(RegBits-1){1'b0}}, 1'b1} << pos;
      end
      CmdMerge: begin
        req.idx  = in_data_i.bitmap_index;
        req.bits = in_data_i.merge_word;
      end
      default: begin
        req.idx  = '0;
        req.bits = '0;
      end
    endcase
  end

  pcsa_update u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .done_o       (done),
    .ones_total_o (total)
  );

  pcsa_estimate u_estimate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (done),
    .ones_total_i (total),
    .phi_i        (phi_q),
    .res_ready_i  (load),
    .res_valid_o  (res_valid),
    .estimate_o   (estimate)
  );

  assign load = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.estimate <= estimate;
      out_q.ones_sum <= total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      phi_q       <= PhiReset;
    end else begin
      if (cfg_we_i) begin
        phi_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/pcsa_checker.sv
// Port-level checks for the PCSA distinct counter, bound to the top level.
// Depends on pcsa_pkg and pcsa_distinct_counter.
`default_nettype none

module pcsa_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire pcsa_pkg::out_item_t out_data_o
);
  import pcsa_pkg::*;

  // result register holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one item in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // a new result only ever follows an item in flight
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without an item in flight");

  // the sum is bounded by the total bitmap width
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.ones_sum <= SumW'(NumRegs * RegBits))
    else $error("ones_sum out of range");

endmodule

bind pcsa_distinct_counter pcsa_checker u_pcsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
